>>> rtl/core/s2l_pkg.sv
package s2l_pkg;

	// Linear light and normalized tristimulus values are unsigned Q1.30.
	localparam int LIN_W = 31;
	// Width of one matrix dot product in units of 1e-4.
	localparam int SUM_W = 44;
	localparam int LUT_N = 256;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0]        lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
	} lab_t;

	typedef logic [LIN_W-1:0] lin_t;
	typedef lin_t lin_lut_t [LUT_N];

	typedef struct packed {
		logic [SUM_W-1:0] sx;
		logic [SUM_W-1:0] sy;
		logic [SUM_W-1:0] sz;
	} xyz_t;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	function automatic longint unsigned pow5_q30(input longint unsigned v);
		longint unsigned p;
		p = v;
		for (int i = 0; i < 4; i++) begin
			p = (p * v) >> 30;
		end
		return p;
	endfunction

	function automatic longint unsigned root5_q30(input longint unsigned u);
		longint unsigned v;
		longint unsigned cand;
		v = 64'd0;
		for (int b = 30; b >= 0; b--) begin
			cand = v | (64'd1 << b);
			if (cand <= ONE_Q30 && pow5_q30(cand) <= u) begin
				v = cand;
			end
		end
		return v;
	endfunction

	// sRGB transfer curve of one 8-bit code, Q1.30.
	function automatic longint unsigned linearize(input longint unsigned code);
		longint unsigned t;
		longint unsigned u;
		longint unsigned r;
		if (code <= 64'd10) begin
			return ((code << 30) * 64'd100) / 64'd329460;
		end
		t = ((64'd1000 * code + 64'd14025) << 30) / 64'd269025;
		u = (t * t) >> 30;
		r = root5_q30(u);
		return (u * r) >> 30;
	endfunction

	function automatic lin_lut_t build_gamma_lut();
		lin_lut_t lut;
		for (int c = 0; c < LUT_N; c++) begin
			lut[c] = LIN_W'(linearize(64'(c)));
		end
		return lut;
	endfunction

	localparam lin_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

>>> rtl/core/s2l_front.sv
module s2l_front
	import s2l_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  pixel_t pixel,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	output xyz_t   xyz,
	output logic   xyz_push,
	input  logic   xyz_full
);

	localparam int CW = 14;
	localparam logic [CW-1:0] COEF [3][3] = '{
		'{14'd4124, 14'd3576, 14'd1805},
		'{14'd2126, 14'd7152, 14'd722},
		'{14'd193,  14'd1192, 14'd9505}
	};

	logic             adv;
	logic             v_s1, v_s2, v_s3;
	lin_t             lin_s1 [3];
	logic [SUM_W-1:0] prod_s2 [3][3];
	logic [SUM_W-1:0] sum_s3 [3];

	// Hold the whole front while a finished transaction waits on a full queue.
	assign pixel_stall = v_s3 && xyz_full;
	assign adv         = !pixel_stall;
	assign xyz_push    = v_s3 && !xyz_full;
	assign xyz         = '{sx: sum_s3[0], sy: sum_s3[1], sz: sum_s3[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s1[0] <= GAMMA_LUT[pixel.red];
			lin_s1[1] <= GAMMA_LUT[pixel.green];
			lin_s1[2] <= GAMMA_LUT[pixel.blue];
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= SUM_W'(lin_s1[c]) * SUM_W'(COEF[r][c]);
				end
				sum_s3[r] <= prod_s2[r][0] + prod_s2[r][1] + prod_s2[r][2];
			end
		end
	end

endmodule

>>> rtl/core/s2l_queue.sv
module s2l_queue
	import s2l_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  xyz_t push_data,
	output logic full,
	input  logic pop,
	output xyz_t pop_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	xyz_t          slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - CW'(1))
		else $error("queue count missed a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> wr_q == rd_q)
		else $error("queue pointers differ while empty");
`endif

endmodule

>>> rtl/core/s2l_back.sv
module s2l_back
	import s2l_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  xyz_t xyz,
	input  logic xyz_valid,
	output logic xyz_pop,
	output lab_t lab,
	output logic lab_valid,
	input  logic lab_stall
);

	localparam int NW     = SUM_W + 3;          // dot product times ten
	localparam int LO_W   = 24;
	localparam int HI_W   = NW - LO_W;
	localparam int MW     = 31;
	localparam int DW     = 17;
	localparam int K_DIV  = 47;
	localparam int ACC_W  = HI_W + MW + LO_W;
	localparam int PW     = 34;                 // 7787*t/8
	localparam int MKW    = 28;
	localparam int QLW    = 27;
	localparam int STEPS  = LIN_W;
	localparam int NSTAGE = 7 + 2 * STEPS + 2;

	localparam logic [DW-1:0] DIV_D [3] = '{17'd95047, 17'd100000, 17'd108883};
	localparam logic [MW-1:0] DIV_M [3] = '{
		MW'((64'd1 << K_DIV) / 64'd95047),
		MW'((64'd1 << K_DIV) / 64'd100000),
		MW'((64'd1 << K_DIV) / 64'd108883)
	};
	localparam logic [MKW-1:0] MK       = MKW'((64'd1 << PW) / 64'd125);
	localparam logic [LIN_W-1:0] THRESH = LIN_W'((64'd8856 << 30) / 64'd1000000);
	localparam logic [LIN_W-1:0] F_OFF  = LIN_W'((64'd16 << 30) / 64'd116);

	typedef struct packed {
		logic [LIN_W-1:0] t;
		logic [LIN_W-1:0] v;
		logic [LIN_W-1:0] fl;
		logic             lin;
		logic [31:0]      sq;
	} root_t;

	logic              adv;
	logic [NSTAGE-1:0] vld_q;
	logic [SUM_W-1:0]  s_in [3];

	logic [NW-1:0]          n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3];
	logic [LO_W+MW-1:0]     lo_s2 [3];
	logic [HI_W+MW-1:0]     hi_s2 [3];
	logic [LIN_W-1:0]       q_s3 [3], q_s4 [3];
	logic [LIN_W+DW-1:0]    qd_s4 [3];
	logic [LIN_W-1:0]       t_s5 [3], t_s6 [3], t_s7 [3];
	logic [PW-1:0]          p_s6 [3], p_s7 [3];
	logic [QLW-1:0]         ql_s7 [3];
	root_t                  root_in [3];
	root_t                  root_a_s [STEPS][3];
	root_t                  root_b_s [STEPS][3];
	logic [LIN_W-1:0]       f_fin [3];
	logic [37:0]            l_s9;
	logic signed [40:0]     a_s9, b_s9;
	lab_t                   lab_q;

	assign adv       = !(lab_valid && lab_stall);
	assign xyz_pop   = adv && xyz_valid;
	assign lab_valid = vld_q[NSTAGE-1];
	assign lab       = lab_q;
	assign s_in[0]   = xyz.sx;
	assign s_in[1]   = xyz.sy;
	assign s_in[2]   = xyz.sz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTAGE-2:0], xyz_valid};
		end
	end

	// Constant division by reciprocal, then one correction step; the linear segment of f follows.
	always_ff @(posedge clk) begin
		logic [ACC_W-1:0] acc;
		logic [NW-1:0]    rem;
		logic [61:0]      pm;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i]  <= (NW'(s_in[i]) << 3) + (NW'(s_in[i]) << 1);
				n_s2[i]  <= n_s1[i];
				lo_s2[i] <= n_s1[i][LO_W-1:0] * DIV_M[i];
				hi_s2[i] <= n_s1[i][NW-1:LO_W] * DIV_M[i];
				acc       = {hi_s2[i], {LO_W{1'b0}}} + ACC_W'(lo_s2[i]);
				q_s3[i]  <= acc[K_DIV +: LIN_W];
				n_s3[i]  <= n_s2[i];
				qd_s4[i] <= q_s3[i] * DIV_D[i];
				q_s4[i]  <= q_s3[i];
				n_s4[i]  <= n_s3[i];
				rem       = n_s4[i] - NW'(qd_s4[i]);
				t_s5[i]  <= q_s4[i] + LIN_W'(rem >= NW'(DIV_D[i]));
				// linear segment of f: floor(7787*t/1000) + 16/116
				p_s6[i]  <= PW'((37'(t_s5[i][23:0]) * 37'd7787) >> 3);
				t_s6[i]  <= t_s5[i];
				pm        = 62'(p_s6[i]) * 62'(MK);
				ql_s7[i] <= pm[PW +: QLW];
				p_s7[i]  <= p_s6[i];
				t_s7[i]  <= t_s6[i];
			end
		end
	end

	always_comb begin
		logic [PW-1:0] rl;
		for (int i = 0; i < 3; i++) begin
			rl              = p_s7[i] - PW'(ql_s7[i]) * PW'(125);
			root_in[i].t    = t_s7[i];
			root_in[i].v    = '0;
			root_in[i].lin  = (t_s7[i] <= THRESH);
			root_in[i].fl   = LIN_W'(ql_s7[i]) + LIN_W'(rl >= PW'(125)) + F_OFF;
			root_in[i].sq   = '0;
		end
	end

	// Cube root, one bit per step: square the candidate, then cube and compare.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int BIT = STEPS - 1 - k;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			root_t                a_in;
			root_t                a_nxt, b_nxt;
			logic [LIN_W-1:0]     cand_a, cand_b;
			logic [2*LIN_W-1:0]   sqf;
			logic [2*LIN_W:0]     cf;

			assign a_in   = (k == 0) ? root_in[i] : root_b_s[(k == 0) ? 0 : k-1][i];
			assign cand_a = a_in.v | (LIN_W'(1) << BIT);
			assign sqf    = (2*LIN_W)'(cand_a) * (2*LIN_W)'(cand_a);
			assign cand_b = root_a_s[k][i].v | (LIN_W'(1) << BIT);
			assign cf     = (2*LIN_W+1)'(root_a_s[k][i].sq) * (2*LIN_W+1)'(cand_b);

			always_comb begin
				a_nxt    = a_in;
				a_nxt.sq = sqf[2*LIN_W-1:30];
			end

			always_comb begin
				b_nxt = root_a_s[k][i];
				if (cf[2*LIN_W:30] <= 33'(root_a_s[k][i].t)) begin
					b_nxt.v = cand_b;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					root_a_s[k][i] <= a_nxt;
					root_b_s[k][i] <= b_nxt;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			f_fin[i] = root_b_s[STEPS-1][i].lin ? root_b_s[STEPS-1][i].fl
			                                    : root_b_s[STEPS-1][i].v;
		end
	end

	function automatic logic signed [15:0] sat16(input logic signed [40:0] x);
		logic        neg;
		logic [40:0] mag;
		logic [40:0] mr;
		neg = x[40];
		mag = neg ? 41'(-x) : 41'(x);
		mr  = (mag + 41'(1 << 21)) >> 22;
		if (neg) begin
			return (mr >= 41'd32768) ? 16'sh8000 : 16'(-mr);
		end
		return (mr > 41'd32767) ? 16'sh7FFF : 16'(mr);
	endfunction

	always_ff @(posedge clk) begin
		logic signed [31:0] dxy, dyz;
		logic [37:0]        lr;
		if (adv) begin
			dxy   = signed'({1'b0, f_fin[0]}) - signed'({1'b0, f_fin[1]});
			dyz   = signed'({1'b0, f_fin[1]}) - signed'({1'b0, f_fin[2]});
			l_s9 <= 38'(f_fin[1]) * 38'd116;
			a_s9 <= 41'(dxy) * 41'sd500;
			b_s9 <= 41'(dyz) * 41'sd200;
			lr    = (l_s9 + 38'(1 << 21)) >> 22;
			if (lr < 38'd4096) begin
				lab_q.lightness <= '0;
			end else if (lr - 38'd4096 > 38'd25600) begin
				lab_q.lightness <= 15'd25600;
			end else begin
				lab_q.lightness <= 15'(lr - 38'd4096);
			end
			lab_q.green_red   <= sat16(a_s9);
			lab_q.blue_yellow <= sat16(b_s9);
		end
	end

endmodule

>>> rtl/core/srgb_to_cielab.sv
// sRGB to CIELAB (D65) converter, one pixel per clock when not stalled. Each
// 8-bit channel is linearized through a 256-entry gamma ROM, run through the
// fixed sRGB->XYZ matrix, normalized by the white point, mapped through the
// CIELAB f() curve (bit-serial cube root, one bit per two pipeline stages,
// or the linear segment near black) and leaves as L in unsigned Q7.8 and a,
// b in signed Q8.8, rounded and saturated. A new pixel transaction is taken
// every cycle unless pixel_stall is high; the rate is one per clock and is
// set by the fully pipelined datapath. An accepted pixel passes 3 front
// stages (ROM, matrix products, sums), the queue, and 71 back stages (5 for
// the constant divides, 2 for the linear f, 62 for the 31-bit cube root, 2
// for scaling and rounding). A front that transforms pixels and a back that
// finishes them are joined by a small queue, so a stall on the result side
// holds only the back while the front fills the queue until it is full.
module srgb_to_cielab
	import s2l_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  pixel_t pixel,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	output lab_t   lab,
	output logic   lab_valid,
	input  logic   lab_stall
);

	xyz_t front_xyz;
	xyz_t head_xyz;
	logic push;
	logic full;
	logic pop;
	logic empty;

	// Linearize and transform to XYZ sums; hold while a finished sum waits on a full queue.
	s2l_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.xyz         (front_xyz),
		.xyz_push    (push),
		.xyz_full    (full)
	);

	// Decouple the two halves so each side stalls on its own.
	s2l_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_xyz),
		.full      (full),
		.pop       (pop),
		.pop_data  (head_xyz),
		.empty     (empty)
	);

	// Normalize, apply f(), scale and saturate; advance unless the result waits.
	s2l_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.xyz       (head_xyz),
		.xyz_valid (!empty),
		.xyz_pop   (pop),
		.lab       (lab),
		.lab_valid (lab_valid),
		.lab_stall (lab_stall)
	);

endmodule
